/* rtl/smcp_pkg.sv */
package smcp_pkg;

	// terminal characters
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_CASE = 8'h20;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_L    = 8'h4C;

	// result kinds
	localparam logic [2:0] KIND_ECHO      = 3'd0;
	localparam logic [2:0] KIND_READ      = 3'd1;
	localparam logic [2:0] KIND_WRITE     = 3'd2;
	localparam logic [2:0] KIND_BURST     = 3'd3;
	localparam logic [2:0] KIND_BAD_CMD   = 3'd4;
	localparam logic [2:0] KIND_BAD_ADDR  = 3'd5;
	localparam logic [2:0] KIND_MODE      = 3'd6;
	localparam logic [2:0] KIND_CANCEL    = 3'd7;

	// one request handed from the front to the back
	typedef struct packed {
		logic        burst;
		logic [2:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
	} job_t;

	// back status seen by the front
	typedef struct packed {
		logic bursting;
		logic burst_done;
	} back_stat_t;

endpackage

/* rtl/smcp_queue.sv */
module smcp_queue
	import smcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_job;
	end

endmodule

/* rtl/smcp_front.sv */
module smcp_front
	import smcp_pkg::*;
#(
	parameter int LINE_BYTES = 64,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       ch,
	input  logic             q_full,
	output logic             push,
	output job_t             push_job,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_idx,
	output logic [7:0]       wr_data,
	output logic [CNT_W-1:0] burst_len,
	input  back_stat_t       back_stat
);

	typedef enum logic [4:0] {
		M_CMD   = 5'b00001,
		M_ADDR  = 5'b00010,
		M_READ  = 5'b00100,
		M_WRITE = 5'b01000,
		M_LINE  = 5'b10000
	} mode_t;

	localparam logic [1:0] PC_NONE = 2'd0;
	localparam logic [1:0] PC_R    = 2'd1;
	localparam logic [1:0] PC_W    = 2'd2;
	localparam logic [1:0] PC_L    = 2'd3;

	mode_t            mode_q, mode_d;
	logic [1:0]       pend_q, pend_d;
	logic [15:0]      addr_q, addr_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] len_q, len_d;
	logic             busy_q, busy_d;
	logic             accept;
	logic [7:0]       up;
	logic             is_dec, is_hex;
	logic [7:0]       letter;

	assign in_ready  = !busy_q && !q_full;
	assign accept    = in_valid && in_ready;
	assign up        = ch & ~CH_CASE;
	assign is_dec    = (ch >= CH_0) && (ch <= CH_9);
	assign is_hex    = (up >= CH_A) && (up <= CH_F);
	assign burst_len = len_q;
	assign wr_idx    = count_q[IDX_W-1:0];
	assign wr_data   = ch;

	always_comb begin
		unique case (pend_q)
			PC_R:    letter = CH_R;
			PC_W:    letter = CH_W;
			PC_L:    letter = CH_L;
			default: letter = 8'h00;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		addr_d   = addr_q;
		count_d  = count_q;
		len_d    = len_q;
		busy_d   = busy_q;
		push     = 1'b0;
		push_job = '{burst: 1'b0, kind: KIND_ECHO, addr: addr_q, data: ch};
		wr_en    = 1'b0;
		if (back_stat.burst_done)
			busy_d = 1'b0;
		if (accept) begin
			unique case (mode_q) inside
				M_ADDR: begin
					if (is_dec) begin
						addr_d = {addr_q[11:0], ch[3:0]};
						push   = 1'b1;
						push_job.addr = addr_d;
					end else if (is_hex) begin
						addr_d = {addr_q[11:0], up[3:0] + 4'd9};
						push   = 1'b1;
						push_job.addr = addr_d;
						push_job.data = up;
					end else if (ch == CH_CR || ch == CH_LF) begin
						if (pend_q != PC_NONE) begin
							unique case (pend_q)
								PC_R:    mode_d = M_READ;
								PC_W:    mode_d = M_WRITE;
								default: mode_d = M_LINE;
							endcase
							count_d = '0;
							push    = 1'b1;
							push_job.kind = KIND_MODE;
							push_job.data = letter;
						end
					end else begin
						mode_d = M_CMD;
						push   = 1'b1;
						push_job.kind = KIND_BAD_ADDR;
					end
				end
				M_READ, M_WRITE: begin
					push = 1'b1;
					if (ch == CH_ESC) begin
						mode_d = M_CMD;
						push_job.kind = KIND_CANCEL;
					end else begin
						addr_d = addr_q + 16'd1;
						if (mode_q == M_READ) begin
							push_job.kind = KIND_READ;
							push_job.data = 8'h00;
						end else begin
							push_job.kind = KIND_WRITE;
						end
					end
				end
				M_LINE: begin
					if (ch == CH_CR) begin
						if (count_q != '0) begin
							push   = 1'b1;
							push_job.burst = 1'b1;
							push_job.kind  = KIND_BURST;
							len_d  = count_q;
							busy_d = 1'b1;
							addr_d = addr_q + 16'(count_q);
						end
						count_d = '0;
					end else if (ch == CH_ESC) begin
						mode_d  = M_CMD;
						count_d = '0;
						push    = 1'b1;
						push_job.kind = KIND_CANCEL;
					end else if (count_q < CNT_W'(LINE_BYTES)) begin
						wr_en   = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				default: begin
					mode_d = M_CMD;
					push   = 1'b1;
					if (up == CH_R || up == CH_W || up == CH_L) begin
						pend_d = (up == CH_R) ? PC_R : ((up == CH_W) ? PC_W : PC_L);
						addr_d = 16'h0000;
						mode_d = M_ADDR;
						push_job.addr = 16'h0000;
						push_job.data = up;
					end else begin
						push_job.kind = KIND_BAD_CMD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_CMD;
			pend_q  <= PC_NONE;
			addr_q  <= 16'h0000;
			count_q <= '0;
			len_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			addr_q  <= addr_d;
			count_q <= count_d;
			len_q   <= len_d;
			busy_q  <= busy_d;
		end
	end

endmodule

/* rtl/smcp_back.sv */
module smcp_back
	import smcp_pkg::*;
#(
	parameter int LINE_BYTES = 64,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  job_t             q_head,
	output logic             pop,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [7:0]       wr_data,
	input  logic [CNT_W-1:0] burst_len,
	output back_stat_t       back_stat,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       out_kind,
	output logic [15:0]      out_addr,
	output logic [7:0]       out_data,
	output logic             out_last
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_BURST = 2'b10
	} state_t;

	state_t           state_q;
	logic [7:0]       line_mem [LINE_BYTES];
	logic [7:0]       rd_data_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rd_idx;
	logic [15:0]      burst_addr_q;
	logic             valid_q;
	logic [2:0]       kind_q;
	logic [15:0]      addr_q;
	logic [7:0]       data_q;
	logic             last_q;
	logic             out_free;
	logic             burst_last;
	logic             burst_step;
	logic             rd_en;
	logic             load;

	assign out_free   = !valid_q || out_ready;
	assign burst_last = (CNT_W'(idx_q) + 1'b1) == burst_len;
	assign burst_step = (state_q == ST_BURST) && out_free;
	assign pop        = (state_q == ST_IDLE) && !q_empty && out_free;
	assign load       = (pop && !q_head.burst) || burst_step;
	assign rd_en      = (pop && q_head.burst) || (burst_step && !burst_last);
	assign rd_idx     = (state_q == ST_IDLE) ? '0 : idx_q + 1'b1;

	assign back_stat.bursting   = (state_q == ST_BURST);
	assign back_stat.burst_done = burst_step && burst_last;

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_addr  = addr_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

	// line buffer, read one byte ahead of the output register
	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem[wr_idx] <= wr_data;
		if (rd_en)
			rd_data_q <= line_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (out_free)
				valid_q <= load;
			unique case (state_q)
				ST_IDLE: begin
					if (pop && q_head.burst) begin
						idx_q   <= '0;
						state_q <= ST_BURST;
					end
				end
				ST_BURST: begin
					if (burst_step) begin
						if (burst_last)
							state_q <= ST_IDLE;
						else
							idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_head.burst)
			burst_addr_q <= q_head.addr;
		else if (burst_step)
			burst_addr_q <= burst_addr_q + 16'd1;
		if (pop && !q_head.burst) begin
			kind_q <= q_head.kind;
			addr_q <= q_head.addr;
			data_q <= q_head.data;
			last_q <= 1'b1;
		end else if (burst_step) begin
			kind_q <= KIND_BURST;
			addr_q <= burst_addr_q;
			data_q <= rd_data_q;
			last_q <= burst_last;
		end
	end

endmodule

/* rtl/serial_memory_command_parser_core.sv */
// Terminal command parser: each character on the slave stream is decoded at
// once in the front stage, which holds the mode, the pending command, the
// current address and the line buffer fill count, and hands at most one
// request per character into a two-entry queue. The back stage drives the
// master stream from an output register, so a request can wait there while
// the next character is taken. A character is taken while the queue has room
// and no burst is pending; most give one result via the queue and the output
// register. A CR in line mode with n buffered bytes starts a burst: the back
// stage streams the bytes from the line buffer one per cycle while the
// output is free, each read one ahead into a register, and the input is held
// off until the last burst byte has entered the output register. The line
// buffer keeps no reset; only bytes written since line mode began are read.
module serial_memory_command_parser_core
	import smcp_pkg::*;
#(
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] mem_address, [23:16] data_byte
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast
);

	localparam int IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
	localparam int CNT_W = $clog2(LINE_BYTES + 1);

	logic             q_push;
	job_t             q_push_job;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	job_t             q_head;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       wr_data;
	logic [CNT_W-1:0] burst_len;
	back_stat_t       back_stat;
	logic [15:0]      out_addr;
	logic [7:0]       out_data;

	smcp_front #(
		.LINE_BYTES(LINE_BYTES),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.ch       (s_tdata),
		.q_full   (q_full),
		.push     (q_push),
		.push_job (q_push_job),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.burst_len(burst_len),
		.back_stat(back_stat)
	);

	smcp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_push_job),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	smcp_back #(
		.LINE_BYTES(LINE_BYTES),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (q_pop),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.burst_len(burst_len),
		.back_stat(back_stat),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (m_tuser),
		.out_addr (out_addr),
		.out_data (out_data),
		.out_last (m_tlast)
	);

	assign m_tdata = {out_data, out_addr};

	// queue is never written while full
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("request queue overflow");

	// the line buffer is not touched while a burst reads it
	assert property (@(posedge clk) disable iff (!arst_n) back_stat.bursting |-> !s_tready)
		else $error("input taken during line burst");

	// only burst bytes may be shown without the last flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != KIND_BURST)) |-> m_tlast)
		else $error("single result without last flag");

	// the bursting state is left once the last burst byte has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.burst_done |=> !back_stat.bursting)
		else $error("burst did not end after its last byte");

endmodule
